### hw/rtl/rdsn_pkg.sv
`timescale 1ns / 1ps
package rdsn_pkg;

  localparam int FULL_SCALE_DEF = 32767;
  localparam logic [14:0] DEADZONE_RST = 15'd7849;
  localparam int SQRT_CELLS = 16;
  localparam int QUOT_BITS = 17;
  localparam int NUM_W = 48;
  localparam int DEN_W = 30;
  // input register, squares, sum, sqrt row, clamp, products, numerators, div row, output
  localparam int LATENCY = 1 + 1 + 1 + SQRT_CELLS + 1 + 1 + 1 + QUOT_BITS + 1;

  typedef struct packed {
    logic               vld;
    logic               dead;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        dz;
  } rdsn_tag_t;

  typedef struct packed {
    logic vld;
    logic dead;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
  } rdsn_dtag_t;

endpackage

### hw/rtl/radial_deadzone_stick_normalizer.sv
`timescale 1ns / 1ps
// channel  | handshake      | payload
// ---------+----------------+------------------------------------
// input    | start / busy   | in_stick_x, in_stick_y
// result   | out_valid      | out_norm_x, out_norm_y
// config   | cfg_wr_en      | cfg_wr_data (deadzone)
//
// One request per cycle; busy is always low.
// The result pipeline is LATENCY deep: 16 square-root cells and 17 divider
// cells set the depth, plus 7 staging registers.
// Synchronous active-low reset clears the valid chain and sets deadzone to 7849.
// The receiver cannot stall; a result is shown for one cycle only.
module radial_deadzone_stick_normalizer
  import rdsn_pkg::*;
#(
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_stick_x,
  input  logic signed [15:0] in_stick_y,
  input  logic               cfg_wr_en,
  input  logic [14:0]        cfg_wr_data,
  output logic               out_valid,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y
);

  localparam logic [15:0] FS = 16'(FULL_SCALE);

  logic [14:0] deadzone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= DEADZONE_RST;
    end else if (cfg_wr_en) begin
      deadzone_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // stage a: capture
  logic               va_r;
  logic signed [15:0] xa_r, ya_r;
  logic [14:0]        dza_r;

  // stage b: squares
  logic               vb_r;
  logic signed [15:0] xb_r, yb_r;
  logic [14:0]        dzb_r;
  logic [31:0]        xx_r, yy_r;
  logic [29:0]        dzsq_r;

  // stage c: sum and deadzone test
  rdsn_tag_t   tc_r;
  logic [31:0] sum_r, sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      tc_r.vld <= 1'b0;
    end else begin
      va_r    <= start & ~busy;
      vb_r    <= va_r;
      tc_r.vld <= vb_r;
    end
    xa_r   <= in_stick_x;
    ya_r   <= in_stick_y;
    dza_r  <= deadzone_r;
    xb_r   <= xa_r;
    yb_r   <= ya_r;
    dzb_r  <= dza_r;
    xx_r   <= 32'(xa_r * xa_r);
    yy_r   <= 32'(ya_r * ya_r);
    dzsq_r <= 30'(dza_r * dza_r);
    tc_r.x  <= xb_r;
    tc_r.y  <= yb_r;
    tc_r.dz <= dzb_r;
    tc_r.dead <= ({1'b0, dzb_r} >= FS) || (sum_nxt <= {2'b00, dzsq_r});
    sum_r  <= sum_nxt;
  end

  assign sum_nxt = xx_r + yy_r;

  // square-root row
  rdsn_tag_t   sq_tag  [SQRT_CELLS+1];
  logic [31:0] sq_bits [SQRT_CELLS+1];
  logic [17:0] sq_rem  [SQRT_CELLS+1];
  logic [15:0] sq_root [SQRT_CELLS+1];

  assign sq_tag[0]  = tc_r;
  assign sq_bits[0] = sum_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    rdsn_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tag_in   (sq_tag[i]),
      .bits_in  (sq_bits[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .tag_out  (sq_tag[i+1]),
      .bits_out (sq_bits[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
  end

  // stage d: clamp magnitude, form differences
  rdsn_tag_t   sqo;
  logic [15:0] mag_c;
  logic        vd_r, deadd_r, nxd_r, nyd_r;
  logic [15:0] axd_r, ayd_r, md_r, dd_r, magd_r;

  assign sqo   = sq_tag[SQRT_CELLS];
  assign mag_c = (sq_root[SQRT_CELLS] > FS) ? FS : sq_root[SQRT_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= sqo.vld;
    end
    deadd_r <= sqo.dead || (mag_c <= {1'b0, sqo.dz});
    nxd_r   <= sqo.x[15];
    nyd_r   <= sqo.y[15];
    axd_r   <= sqo.x[15] ? 16'(-sqo.x) : sqo.x;
    ayd_r   <= sqo.y[15] ? 16'(-sqo.y) : sqo.y;
    md_r    <= mag_c - {1'b0, sqo.dz};
    dd_r    <= FS - {1'b0, sqo.dz};
    magd_r  <= mag_c;
  end

  // stage e: products
  logic             ve_r, deade_r, nxe_r, nye_r;
  logic [31:0]      pxe_r, pye_r;
  logic [DEN_W-1:0] dene_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= vd_r;
    end
    deade_r <= deadd_r;
    nxe_r   <= nxd_r;
    nye_r   <= nyd_r;
    pxe_r   <= {16'b0, axd_r} * {16'b0, md_r};
    pye_r   <= {16'b0, ayd_r} * {16'b0, md_r};
    dene_r  <= DEN_W'(dd_r * magd_r);
  end

  // stage f: numerators times 32767, overflow test
  rdsn_dtag_t       tf_r;
  logic [DEN_W-1:0] denf_r;
  logic [NUM_W-1:0] numx_r, numy_r, numx_c, numy_c, den_top;

  assign numx_c  = (NUM_W'(pxe_r) << 15) - NUM_W'(pxe_r);
  assign numy_c  = (NUM_W'(pye_r) << 15) - NUM_W'(pye_r);
  assign den_top = NUM_W'(dene_r) << QUOT_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tf_r.vld <= 1'b0;
    end else begin
      tf_r.vld <= ve_r;
    end
    tf_r.dead  <= deade_r;
    tf_r.neg_x <= nxe_r;
    tf_r.neg_y <= nye_r;
    tf_r.sat_x <= numx_c >= den_top;
    tf_r.sat_y <= numy_c >= den_top;
    denf_r     <= dene_r;
    numx_r     <= numx_c;
    numy_r     <= numy_c;
  end

  // divider row, most significant quotient bit first
  rdsn_dtag_t           dv_tag [QUOT_BITS+1];
  logic [DEN_W-1:0]     dv_den [QUOT_BITS+1];
  logic [NUM_W-1:0]     dv_rx  [QUOT_BITS+1];
  logic [NUM_W-1:0]     dv_ry  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] dv_qx  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] dv_qy  [QUOT_BITS+1];

  assign dv_tag[0] = tf_r;
  assign dv_den[0] = denf_r;
  assign dv_rx[0]  = numx_r;
  assign dv_ry[0]  = numy_r;
  assign dv_qx[0]  = '0;
  assign dv_qy[0]  = '0;

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
    rdsn_div_cell #(.BIT(QUOT_BITS - 1 - j)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tag_in    (dv_tag[j]),
      .den_in    (dv_den[j]),
      .rem_x_in  (dv_rx[j]),
      .rem_y_in  (dv_ry[j]),
      .q_x_in    (dv_qx[j]),
      .q_y_in    (dv_qy[j]),
      .tag_out   (dv_tag[j+1]),
      .den_out   (dv_den[j+1]),
      .rem_x_out (dv_rx[j+1]),
      .rem_y_out (dv_ry[j+1]),
      .q_x_out   (dv_qx[j+1]),
      .q_y_out   (dv_qy[j+1])
    );
  end

  // output: zero in the deadzone, else saturate and apply sign
  rdsn_dtag_t         dvo;
  logic               out_valid_r;
  logic signed [15:0] out_norm_x_r, out_norm_y_r, nx_nxt, ny_nxt;

  assign dvo = dv_tag[QUOT_BITS];

  function automatic logic [15:0] fin(input logic [QUOT_BITS-1:0] q, input logic neg,
                                      input logic sat);
    logic [QUOT_BITS-1:0] qc;
    qc = q;
    if (neg) begin
      if (sat || q > QUOT_BITS'(32768)) qc = QUOT_BITS'(32768);
      fin = 16'(-qc);
    end else begin
      if (sat || q > QUOT_BITS'(32767)) qc = QUOT_BITS'(32767);
      fin = qc[15:0];
    end
  endfunction

  assign nx_nxt = dvo.dead ? 16'sd0 : fin(dv_qx[QUOT_BITS], dvo.neg_x, dvo.sat_x);
  assign ny_nxt = dvo.dead ? 16'sd0 : fin(dv_qy[QUOT_BITS], dvo.neg_y, dvo.sat_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dvo.vld;
    end
    out_norm_x_r <= nx_nxt;
    out_norm_y_r <= ny_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_norm_x = out_norm_x_r;
  assign out_norm_y = out_norm_y_r;

endmodule

### hw/rtl/rdsn_sqrt_cell.sv
`timescale 1ns / 1ps
module rdsn_sqrt_cell
  import rdsn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rdsn_tag_t   tag_in,
  input  logic [31:0] bits_in,
  input  logic [17:0] rem_in,
  input  logic [15:0] root_in,
  output rdsn_tag_t   tag_out,
  output logic [31:0] bits_out,
  output logic [17:0] rem_out,
  output logic [15:0] root_out
);

  rdsn_tag_t   tag_r;
  logic [31:0] bits_r;
  logic [17:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;
  logic [20:0] diff;

  // one root digit per cell
  always_comb begin
    diff = {1'b0, rem_in, bits_in[31:30]} - {3'b0, root_in, 2'b01};
    if (diff[20]) begin
      rem_nxt  = {rem_in[15:0], bits_in[31:30]};
      root_nxt = {root_in[14:0], 1'b0};
    end else begin
      rem_nxt  = diff[17:0];
      root_nxt = {root_in[14:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r.vld <= tag_in.vld;
    end
    tag_r.dead <= tag_in.dead;
    tag_r.x    <= tag_in.x;
    tag_r.y    <= tag_in.y;
    tag_r.dz   <= tag_in.dz;
    bits_r     <= {bits_in[29:0], 2'b00};
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
  end

  assign tag_out  = tag_r;
  assign bits_out = bits_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;

endmodule

### hw/rtl/rdsn_div_cell.sv
`timescale 1ns / 1ps
module rdsn_div_cell
  import rdsn_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rdsn_dtag_t           tag_in,
  input  logic [DEN_W-1:0]     den_in,
  input  logic [NUM_W-1:0]     rem_x_in,
  input  logic [NUM_W-1:0]     rem_y_in,
  input  logic [QUOT_BITS-1:0] q_x_in,
  input  logic [QUOT_BITS-1:0] q_y_in,
  output rdsn_dtag_t           tag_out,
  output logic [DEN_W-1:0]     den_out,
  output logic [NUM_W-1:0]     rem_x_out,
  output logic [NUM_W-1:0]     rem_y_out,
  output logic [QUOT_BITS-1:0] q_x_out,
  output logic [QUOT_BITS-1:0] q_y_out
);

  rdsn_dtag_t           tag_r;
  logic [DEN_W-1:0]     den_r;
  logic [NUM_W-1:0]     rem_x_r, rem_y_r, rem_x_nxt, rem_y_nxt, dsh;
  logic [QUOT_BITS-1:0] q_x_r, q_y_r, q_x_nxt, q_y_nxt;

  always_comb begin
    dsh       = NUM_W'(den_in) << BIT;
    rem_x_nxt = rem_x_in;
    rem_y_nxt = rem_y_in;
    q_x_nxt   = q_x_in;
    q_y_nxt   = q_y_in;
    if (rem_x_in >= dsh) begin
      rem_x_nxt    = rem_x_in - dsh;
      q_x_nxt[BIT] = 1'b1;
    end
    if (rem_y_in >= dsh) begin
      rem_y_nxt    = rem_y_in - dsh;
      q_y_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r.vld <= tag_in.vld;
    end
    tag_r.dead  <= tag_in.dead;
    tag_r.neg_x <= tag_in.neg_x;
    tag_r.neg_y <= tag_in.neg_y;
    tag_r.sat_x <= tag_in.sat_x;
    tag_r.sat_y <= tag_in.sat_y;
    den_r       <= den_in;
    rem_x_r     <= rem_x_nxt;
    rem_y_r     <= rem_y_nxt;
    q_x_r       <= q_x_nxt;
    q_y_r       <= q_y_nxt;
  end

  assign tag_out   = tag_r;
  assign den_out   = den_r;
  assign rem_x_out = rem_x_r;
  assign rem_y_out = rem_y_r;
  assign q_x_out   = q_x_r;
  assign q_y_out   = q_y_r;

endmodule

### hw/rtl/rdsn_checker.sv
`timescale 1ns / 1ps
module rdsn_checker
  import rdsn_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] in_stick_x,
  input logic signed [15:0] in_stick_y,
  input logic               cfg_wr_en,
  input logic [14:0]        cfg_wr_data,
  input logic               out_valid,
  input logic signed [15:0] out_norm_x,
  input logic signed [15:0] out_norm_y
);

  // every result traces back to a request a fixed depth earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start & ~busy, LATENCY))
    else $error("result without request");

  a_centered_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_stick_x == 16'sd0 && in_stick_y == 16'sd0) |->
      ##LATENCY (out_valid && out_norm_x == 16'sd0 && out_norm_y == 16'sd0))
    else $error("centered stick not zero");

  a_sign_x: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_stick_x[15]) |-> ##LATENCY (out_valid && !out_norm_x[15]))
    else $error("x sign flipped");

  a_sign_y: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_stick_y[15]) |-> ##LATENCY (out_valid && !out_norm_y[15]))
    else $error("y sign flipped");

endmodule

bind radial_deadzone_stick_normalizer rdsn_checker u_rdsn_checker (.*);
